// File: hdl/light_sensor_hysteresis_monitor_top_assert.svh
// Assertion macros for the light sensor monitor checker.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef LIGHT_SENSOR_HYSTERESIS_MONITOR_TOP_ASSERT_SVH
`define LIGHT_SENSOR_HYSTERESIS_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define LSHM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lshm assertion failed");

// Next-cycle implication.
`define LSHM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lshm assertion failed");

`endif

// File: hdl/lshm_pkg.sv
package lshm_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int TIMER_BITS  = 24;
    localparam int THR_BITS    = 16;
    localparam int HYST_BITS   = 10;
    // Compare width: threshold plus or minus a margin never leaves this range.
    localparam int CMP_W       = THR_BITS + 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [THR_BITS-1:0] THR_RESET     = 16'sh7FFF;
    localparam logic [HYST_BITS-1:0]       HYST_RESET    = 10'd16;
    localparam logic [TIMER_BITS-1:0]      TIMEOUT_RESET = TIMER_BITS'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_HYST_ON       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_OFF      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_TIMEOUT = 2'd2;

    localparam logic [2:0] CMD_SAMPLE    = 3'd0;
    localparam logic [2:0] CMD_SET_THR   = 3'd1;
    localparam logic [2:0] CMD_CAL_START = 3'd2;
    localparam logic [2:0] CMD_CAL_EXIT  = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_SET_THR,
        OP_CAL_START,
        OP_CAL_EXIT,
        OP_TICK
    } op_kind_t;

    typedef enum logic [1:0] {
        MODE_ON      = 2'd0,
        MODE_OFF     = 2'd1,
        MODE_CAL_ON  = 2'd2,
        MODE_CAL_OFF = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        SCR_LIGHTS_ON          = 3'd0,
        SCR_LIGHTS_OFF_DELAYED = 3'd1,
        SCR_CALIB_ON           = 3'd2,
        SCR_BLINK2             = 3'd3,
        SCR_BLINK3_ON          = 3'd4,
        SCR_BLINK_END_OFF      = 3'd5
    } script_t;

    typedef struct packed {
        logic [2:0]                 cmd;
        logic [SAMPLE_BITS-1:0]     light_sample;
        logic signed [THR_BITS-1:0] threshold_value;
    } cmd_req_t;

    typedef struct packed {
        logic [2:0] script_id;
        logic       high_priority;
        logic [1:0] new_mode;
        logic       last;
    } script_res_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic [SAMPLE_BITS-1:0]     sample;
        logic signed [THR_BITS-1:0] threshold;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hdl/lshm_front.sv
module lshm_front (
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  lshm_pkg::cmd_req_t  cmd_data,
    input  lshm_pkg::q_status_t q_status,
    output logic                push,
    output lshm_pkg::op_t       push_op
);

    logic known;

    assign cmd_ready = !q_status.full;

    // Decode the command; drop unknown codes here so they never reach the back end.
    always_comb
    begin
        known             = 1'b1;
        push_op.kind      = lshm_pkg::OP_SAMPLE;
        push_op.sample    = cmd_data.light_sample;
        push_op.threshold = cmd_data.threshold_value;
        case (cmd_data.cmd)
            lshm_pkg::CMD_SAMPLE:    push_op.kind = lshm_pkg::OP_SAMPLE;
            lshm_pkg::CMD_SET_THR:   push_op.kind = lshm_pkg::OP_SET_THR;
            lshm_pkg::CMD_CAL_START: push_op.kind = lshm_pkg::OP_CAL_START;
            lshm_pkg::CMD_CAL_EXIT:  push_op.kind = lshm_pkg::OP_CAL_EXIT;
            lshm_pkg::CMD_TICK:      push_op.kind = lshm_pkg::OP_TICK;
            default:                 known = 1'b0;
        endcase
    end

    assign push = cmd_valid && cmd_ready && known;

endmodule

// File: hdl/lshm_queue.sv
module lshm_queue #(
    parameter int DEPTH = lshm_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lshm_pkg::op_t       push_op,
    input  logic                pop,
    output lshm_pkg::op_t       head_op,
    output lshm_pkg::q_status_t q_status
);

    // Depth of two or more.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lshm_pkg::op_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op        = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

// File: hdl/lshm_back.sv
module lshm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lshm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lshm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  lshm_pkg::op_t                     head_op,
    input  lshm_pkg::q_status_t               q_status,
    output logic                              pop,
    output logic                              script_valid,
    input  logic                              script_ready,
    output lshm_pkg::script_res_t             script_data
);

    localparam int CMP_W  = lshm_pkg::CMP_W;
    localparam int THR_W  = lshm_pkg::THR_BITS;
    localparam int HYST_W = lshm_pkg::HYST_BITS;
    localparam int SAMP_W = lshm_pkg::SAMPLE_BITS;
    localparam int TIM_W  = lshm_pkg::TIMER_BITS;

    function automatic lshm_pkg::script_res_t make_res(
        lshm_pkg::script_t s, logic hi, lshm_pkg::mode_t m, logic lst);
        lshm_pkg::script_res_t r;
        r.script_id     = s;
        r.high_priority = hi;
        r.new_mode      = m;
        r.last          = lst;
        return r;
    endfunction

    // Configuration registers
    logic [HYST_W-1:0] hyst_on_reg;
    logic [HYST_W-1:0] hyst_off_reg;
    logic [TIM_W-1:0]  timeout_reg;

    // Detector state
    lshm_pkg::mode_t         mode_reg, mode_next;
    logic signed [THR_W-1:0] thr_reg, thr_next;
    logic [TIM_W-1:0]        remain_reg, remain_next;
    logic                    running_reg, running_next;

    // Output stage and the second result of a calibration exit
    logic                  out_valid_reg, out_valid_next;
    lshm_pkg::script_res_t out_data_reg, out_data_next;
    logic                  pend_reg, pend_next;
    lshm_pkg::script_res_t pend_data_reg, pend_data_next;

    logic signed [CMP_W-1:0] samp_x, thr_x, hon_x, hoff_x;
    logic                    enter, leave, load;
    logic [1:0]              n_res;
    lshm_pkg::script_res_t   res0, res1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_on_reg  <= lshm_pkg::HYST_RESET;
            hyst_off_reg <= lshm_pkg::HYST_RESET;
            timeout_reg  <= lshm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lshm_pkg::CFG_HYST_ON:       hyst_on_reg  <= cfg_data[HYST_W-1:0];
                lshm_pkg::CFG_HYST_OFF:      hyst_off_reg <= cfg_data[HYST_W-1:0];
                lshm_pkg::CFG_CALIB_TIMEOUT: timeout_reg  <= cfg_data[TIM_W-1:0];
                default:                     ;
            endcase
        end
    end

    assign samp_x = {{(CMP_W - SAMP_W){1'b0}}, head_op.sample};
    assign thr_x  = {{(CMP_W - THR_W){thr_reg[THR_W-1]}}, thr_reg};
    assign hon_x  = {{(CMP_W - HYST_W){1'b0}}, hyst_on_reg};
    assign hoff_x = {{(CMP_W - HYST_W){1'b0}}, hyst_off_reg};

    // Execute the operation at the queue head against the current state.
    always_comb
    begin
        mode_next    = mode_reg;
        thr_next     = thr_reg;
        remain_next  = remain_reg;
        running_next = running_reg;
        enter        = 1'b0;
        leave        = 1'b0;
        n_res        = 2'd0;
        res0         = '0;
        res1         = '0;
        case (head_op.kind)
            lshm_pkg::OP_SAMPLE:
            begin
                case (mode_reg)
                    lshm_pkg::MODE_OFF:
                    begin
                        if (samp_x < thr_x - hon_x)
                        begin
                            mode_next = lshm_pkg::MODE_ON;
                            n_res     = 2'd1;
                            res0      = make_res(lshm_pkg::SCR_LIGHTS_ON, 1'b0,
                                                 lshm_pkg::MODE_ON, 1'b1);
                        end
                    end
                    lshm_pkg::MODE_ON:
                    begin
                        if (samp_x >= thr_x + hoff_x)
                        begin
                            mode_next = lshm_pkg::MODE_OFF;
                            n_res     = 2'd1;
                            res0      = make_res(lshm_pkg::SCR_LIGHTS_OFF_DELAYED, 1'b0,
                                                 lshm_pkg::MODE_OFF, 1'b1);
                        end
                    end
                    lshm_pkg::MODE_CAL_OFF:
                    begin
                        if (samp_x < thr_x)
                        begin
                            mode_next = lshm_pkg::MODE_CAL_ON;
                            n_res     = 2'd1;
                            res0      = make_res(lshm_pkg::SCR_CALIB_ON, 1'b0,
                                                 lshm_pkg::MODE_CAL_ON, 1'b1);
                        end
                    end
                    default:
                    begin
                        if (samp_x >= thr_x)
                        begin
                            mode_next = lshm_pkg::MODE_CAL_OFF;
                            n_res     = 2'd1;
                            res0      = make_res(lshm_pkg::SCR_LIGHTS_ON, 1'b0,
                                                 lshm_pkg::MODE_CAL_OFF, 1'b1);
                        end
                    end
                endcase
            end
            lshm_pkg::OP_SET_THR:
            begin
                if (head_op.threshold != thr_reg)
                begin
                    thr_next = head_op.threshold;
                    enter    = 1'b1;
                end
            end
            lshm_pkg::OP_CAL_START: enter = 1'b1;
            lshm_pkg::OP_CAL_EXIT:  leave = 1'b1;
            lshm_pkg::OP_TICK:
            begin
                if (running_reg)
                begin
                    if (remain_reg <= TIM_W'(1))
                    begin
                        leave = 1'b1;
                    end
                    else
                    begin
                        remain_next = remain_reg - 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // Enter calibration only from a normal mode.
        if (enter && (mode_reg == lshm_pkg::MODE_ON || mode_reg == lshm_pkg::MODE_OFF))
        begin
            remain_next  = timeout_reg;
            running_next = 1'b1;
            n_res        = 2'd1;
            if (mode_reg == lshm_pkg::MODE_OFF)
            begin
                mode_next = lshm_pkg::MODE_CAL_OFF;
                res0      = make_res(lshm_pkg::SCR_BLINK3_ON, 1'b0,
                                     lshm_pkg::MODE_CAL_OFF, 1'b1);
            end
            else
            begin
                mode_next = lshm_pkg::MODE_CAL_ON;
                res0      = make_res(lshm_pkg::SCR_BLINK2, 1'b0,
                                     lshm_pkg::MODE_CAL_ON, 1'b1);
            end
        end

        // Stop the counter; emit the end script pair only when calibrating.
        if (leave)
        begin
            running_next = 1'b0;
            remain_next  = '0;
            if (mode_reg == lshm_pkg::MODE_CAL_ON)
            begin
                mode_next = lshm_pkg::MODE_ON;
                n_res     = 2'd2;
                res0      = make_res(lshm_pkg::SCR_BLINK2, 1'b1, lshm_pkg::MODE_ON, 1'b0);
                res1      = make_res(lshm_pkg::SCR_LIGHTS_ON, 1'b0, lshm_pkg::MODE_ON, 1'b1);
            end
            else if (mode_reg == lshm_pkg::MODE_CAL_OFF)
            begin
                mode_next = lshm_pkg::MODE_OFF;
                n_res     = 2'd2;
                res0      = make_res(lshm_pkg::SCR_BLINK_END_OFF, 1'b1,
                                     lshm_pkg::MODE_OFF, 1'b0);
                res1      = make_res(lshm_pkg::SCR_LIGHTS_OFF_DELAYED, 1'b0,
                                     lshm_pkg::MODE_OFF, 1'b1);
            end
        end
    end

    // Refill the output register when it is empty or being taken.
    assign load = !out_valid_reg || script_ready;
    assign pop  = load && !pend_reg && !q_status.empty;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        if (load)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = pend_data_reg;
                pend_next      = 1'b0;
            end
            else if (!q_status.empty)
            begin
                out_valid_next = (n_res != 2'd0);
                out_data_next  = res0;
                pend_next      = (n_res == 2'd2);
                pend_data_next = res1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= lshm_pkg::MODE_ON;
            thr_reg       <= lshm_pkg::THR_RESET;
            remain_reg    <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg    <= mode_next;
                thr_reg     <= thr_next;
                remain_reg  <= remain_next;
                running_reg <= running_next;
            end
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    assign script_valid = out_valid_reg;
    assign script_data  = out_data_reg;

endmodule

// File: hdl/light_sensor_hysteresis_monitor_top.sv
// Channel   Direction  Payload                     Completes when
// cmd       in         lshm_pkg::cmd_req_t         cmd_valid && cmd_ready
// script    out        lshm_pkg::script_res_t      script_valid && script_ready
// cfg       in         cfg_index, cfg_data         cfg_valid && cfg_ready (always ready)
//
// A request is taken every cycle while the command queue has room; it is written into the
// queue and then loaded into the output register before its first result is valid.
// The back end retires one request a cycle while its output register can load; a calibration
// exit holds it until its second result has also been loaded into the output register.
// Reset (rst_n low, asynchronous) empties queue and output, sets lights-on, threshold 32767.
// A stalled script port backs up into the queue and then drops cmd_ready.
module light_sensor_hysteresis_monitor_top #(
    parameter int QUEUE_DEPTH = lshm_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  lshm_pkg::cmd_req_t              cmd_data,
    output logic                            script_valid,
    input  logic                            script_ready,
    output lshm_pkg::script_res_t           script_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lshm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lshm_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                push;
    logic                pop;
    lshm_pkg::op_t       push_op;
    lshm_pkg::op_t       head_op;
    lshm_pkg::q_status_t q_status;

    // Front end: decode requests and drop unknown commands.
    lshm_front u_front (
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .q_status  (q_status),
        .push      (push),
        .push_op   (push_op)
    );

    // Decoupling queue: hold decoded operations while the back end stalls.
    lshm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    // Back end: hysteresis compare, calibration timer, mode state and result output.
    lshm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .head_op      (head_op),
        .q_status     (q_status),
        .pop          (pop),
        .script_valid (script_valid),
        .script_ready (script_ready),
        .script_data  (script_data)
    );

endmodule

// File: hdl/lshm_checker.sv
`include "light_sensor_hysteresis_monitor_top_assert.svh"

module lshm_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  script_valid,
    input logic                  script_ready,
    input lshm_pkg::script_res_t script_data
);

    logic out_stall;
    logic hi_take;
    logic lo_final;
    logic mid_res;
    logic normal_mode;

    assign out_stall   = script_valid && !script_ready;
    assign hi_take     = script_valid && script_ready && script_data.high_priority;
    assign lo_final    = script_valid && !script_data.high_priority && script_data.last;
    assign mid_res     = script_valid && !script_data.last;
    assign normal_mode = (script_data.new_mode == lshm_pkg::MODE_ON) ||
                         (script_data.new_mode == lshm_pkg::MODE_OFF);

    // Hold a stalled result.
    `LSHM_ASSERT_NEXT(a_out_hold, out_stall, script_valid && $stable(script_data))

    // A high-priority end script always has a follower.
    `LSHM_ASSERT_IMPL(a_hi_not_last, script_valid, !(script_data.high_priority && script_data.last))

    // The low-priority state script follows the end script at once, same mode.
    `LSHM_ASSERT_NEXT(a_hi_then_lo, hi_take, lo_final && $stable(script_data.new_mode))

    // A non-final result only leaves calibration into a normal mode.
    `LSHM_ASSERT_IMPL(a_mid_mode, mid_res, script_data.high_priority && normal_mode)

endmodule

bind light_sensor_hysteresis_monitor_top lshm_checker u_lshm_checker (.*);
